### rtl/core/pfa_pkg.sv
package pfa_pkg;

  typedef logic [2:0]        mode_t;
  typedef logic [31:0]       value_t;
  typedef logic signed [7:0] shift_t;

  localparam mode_t MODE_EXTRACT = 3'd0;
  localparam mode_t MODE_GREATER = 3'd1;
  localparam mode_t MODE_LESS    = 3'd2;
  localparam mode_t MODE_ADD     = 3'd3;
  localparam mode_t MODE_SUB     = 3'd4;
  localparam mode_t MODE_MUL     = 3'd5;
  localparam mode_t MODE_DIV     = 3'd6;

  localparam value_t     ALL_ONES      = 32'hFFFF_FFFF;
  localparam logic [5:0] WORD_BITS     = 6'd32;
  localparam logic [5:0] DIV_KEEP_BITS = 6'd16;
  localparam logic [5:0] NIBBLE        = 6'd4;

endpackage

### rtl/core/pfa_if.sv
interface pfa_in_if;
  logic           valid;
  logic           ready;
  pfa_pkg::mode_t  mode;
  pfa_pkg::value_t value_a;
  pfa_pkg::shift_t shift_a;
  pfa_pkg::value_t value_b;
  pfa_pkg::shift_t shift_b;

  modport source (output valid, mode, value_a, shift_a, value_b, shift_b, input ready);
  modport sink (input valid, mode, value_a, shift_a, value_b, shift_b, output ready);
endinterface

interface pfa_out_if;
  logic            valid;
  logic            ready;
  pfa_pkg::value_t result_value;
  pfa_pkg::shift_t result_shift;

  modport source (output valid, result_value, result_shift, input ready);
  modport sink (input valid, result_value, result_shift, output ready);
endinterface

### rtl/core/pseudo_float_alu_unit.sv
// Pseudo-float ALU: operands are a 32-bit unsigned mantissa and an 8-bit signed exponent.
// One item is taken at a time; the block runs a bit-serial sequencer. Every item first
// counts the leading zeros of both mantissas one bit per cycle, then passes through a
// setup state. Extract, compare, add and subtract then shift one operand where needed,
// a bit per cycle (by up to 32 bits), and go to the finish state. Multiply drops one
// nibble per cycle (up to 8 nibbles) and runs a shift-and-add over 32 multiplier bits.
// Divide runs a radix-2 restoring divider producing 32 quotient bits. The finish state
// waits until the output register is free. A finished result sits in the output
// register while the next item is taken.
module pseudo_float_alu_unit (
  input  logic          clk,
  input  logic          rst_n,
  pfa_in_if.sink        in_ch,
  pfa_out_if.source     out_ch
);
  import pfa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LZ    = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_NIB   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]  state_r, state_nxt;
  mode_t       mode_r, mode_nxt;
  value_t      a_r, a_nxt, b_r, b_nxt, ta_r, ta_nxt, tb_r, tb_nxt, acc_r, acc_nxt;
  shift_t      sa_r, sa_nxt, sb_r, sb_nxt;
  logic [5:0]  lza_r, lza_nxt, lzb_r, lzb_nxt, cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        sel_b_r, sel_b_nxt, left_r, left_nxt;
  logic        early_r, early_nxt, keyres_r, keyres_nxt;
  logic        out_valid_r, out_valid_nxt;
  value_t      out_value_r, out_value_nxt;
  shift_t      out_shift_r, out_shift_nxt;

  logic [7:0]  sa_u, sb_u, lza8, lzb8, dab, dba, neg_sa, div_adj;
  logic signed [7:0] key_a, key_b;
  logic        a_hi, a_done, b_done;
  logic [15:0] dv;
  logic [16:0] div_r2;
  logic [17:0] div_sub;
  logic        halve, is_add, gt, lt;
  value_t      add_x, add_y, fin_value;
  logic [32:0] sum33;
  shift_t      fin_shift;

  function automatic logic [5:0] clamp_shift(input logic [7:0] n);
    clamp_shift = (n >= 8'd32) ? WORD_BITS : n[5:0];
  endfunction

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.result_shift = out_shift_r;

  assign sa_u    = sa_r;
  assign sb_u    = sb_r;
  assign lza8    = {2'b00, lza_r};
  assign lzb8    = {2'b00, lzb_r};
  assign dab     = sa_u - sb_u;
  assign dba     = sb_u - sa_u;
  assign neg_sa  = 8'd0 - sa_u;
  assign key_a   = lza8 - sa_u;
  assign key_b   = lzb8 - sb_u;
  assign a_hi    = (sa_r > sb_r);
  assign a_done  = ta_r[31] || (lza_r == WORD_BITS);
  assign b_done  = tb_r[31] || (lzb_r == WORD_BITS);
  // divisor cut to 16 bits: top 16 bits of the normalized divisor, or the divisor itself if it fits
  assign dv      = (lzb_r < DIV_KEEP_BITS) ? tb_r[31:16] : b_r[15:0];
  assign div_adj = (lzb_r < DIV_KEEP_BITS) ? {2'b00, DIV_KEEP_BITS - lzb_r} : 8'd0;

  assign div_r2  = {rem_r, a_r[31]};
  assign div_sub = {1'b0, div_r2} - {2'b00, b_r[15:0]};

  // shared adder: add, or a - b for subtract and compare
  assign is_add = (mode_r == MODE_ADD);
  assign halve  = is_add && (a_r[31] || b_r[31]);
  assign add_x  = halve ? {1'b0, a_r[31:1]} : a_r;
  assign add_y  = is_add ? (halve ? {1'b0, b_r[31:1]} : b_r) : ~b_r;
  assign sum33  = {1'b0, add_x} + {1'b0, add_y} + {32'd0, !is_add};
  assign lt     = !sum33[32];
  assign gt     = sum33[32] && (sum33[31:0] != 32'd0);

  always_comb begin
    fin_value = '0;
    fin_shift = '0;
    case (mode_r)
      MODE_EXTRACT: fin_value = early_r ? ALL_ONES : a_r;
      MODE_GREATER: fin_value = {31'd0, early_r ? keyres_r : gt};
      MODE_LESS:    fin_value = {31'd0, early_r ? keyres_r : lt};
      MODE_ADD: begin
        fin_value = sum33[31:0];
        fin_shift = halve ? shift_t'(sa_u + 8'd1) : sa_r;
      end
      MODE_SUB: begin
        fin_value = gt ? sum33[31:0] : 32'd0;
        fin_shift = sa_r;
      end
      MODE_MUL: begin
        fin_value = acc_r;
        fin_shift = sa_r;
      end
      MODE_DIV: begin
        fin_value = early_r ? ALL_ONES : a_r;
        fin_shift = sa_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    acc_nxt       = acc_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    lza_nxt       = lza_r;
    lzb_nxt       = lzb_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    sel_b_nxt     = sel_b_r;
    left_nxt      = left_r;
    early_nxt     = early_r;
    keyres_nxt    = keyres_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_shift_nxt = out_shift_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = in_ch.mode;
          a_nxt     = in_ch.value_a;
          ta_nxt    = in_ch.value_a;
          sa_nxt    = in_ch.shift_a;
          b_nxt     = in_ch.value_b;
          tb_nxt    = in_ch.value_b;
          sb_nxt    = in_ch.shift_b;
          lza_nxt   = '0;
          lzb_nxt   = '0;
          state_nxt = S_LZ;
        end
      end
      S_LZ: begin
        // normalize copies one bit a cycle, counting the zeros
        if (!a_done) begin
          ta_nxt  = {ta_r[30:0], 1'b0};
          lza_nxt = lza_r + 6'd1;
        end
        if (!b_done) begin
          tb_nxt  = {tb_r[30:0], 1'b0};
          lzb_nxt = lzb_r + 6'd1;
        end
        if (a_done && b_done) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        early_nxt  = 1'b0;
        keyres_nxt = 1'b0;
        cnt_nxt    = '0;
        sel_b_nxt  = 1'b0;
        left_nxt   = 1'b1;
        state_nxt  = S_FIN;
        case (mode_r)
          MODE_EXTRACT: begin
            if (!sa_r[7] && (sa_u != 8'd0)) begin
              if (sa_u > lza8) early_nxt = 1'b1;
              else cnt_nxt = clamp_shift(sa_u);
            end else if (sa_r[7]) begin
              cnt_nxt  = clamp_shift(neg_sa);
              left_nxt = 1'b0;
            end
          end
          MODE_GREATER, MODE_LESS: begin
            if (key_a != key_b) begin
              early_nxt  = 1'b1;
              keyres_nxt = (mode_r == MODE_LESS) ? (key_a > key_b) : (key_a < key_b);
            end else if (!key_a[7]) begin
              sel_b_nxt = !a_hi;
              cnt_nxt   = clamp_shift(a_hi ? dab : dba);
            end else begin
              sel_b_nxt = a_hi;
              left_nxt  = 1'b0;
              cnt_nxt   = clamp_shift(a_hi ? dab : dba);
            end
          end
          MODE_ADD, MODE_SUB: begin
            if (a_hi) begin
              cnt_nxt = clamp_shift(dab);
              if (dab <= lza8) begin
                sa_nxt = sb_r;
              end else begin
                sel_b_nxt = 1'b1;
                left_nxt  = 1'b0;
              end
            end else if (sa_r != sb_r) begin
              cnt_nxt = clamp_shift(dba);
              if (dba <= lzb8) begin
                sel_b_nxt = 1'b1;
              end else begin
                left_nxt = 1'b0;
                sa_nxt   = sb_r;
              end
            end
          end
          MODE_MUL: begin
            sa_nxt    = shift_t'(sa_u + sb_u);
            state_nxt = S_NIB;
          end
          MODE_DIV: begin
            sa_nxt  = shift_t'(sa_u - lza8 - sb_u + div_adj);
            a_nxt   = ta_r;
            b_nxt   = {16'd0, dv};
            rem_nxt = '0;
            if (dv == 16'd0) begin
              early_nxt = 1'b1;
            end else begin
              cnt_nxt   = WORD_BITS;
              state_nxt = S_DIV;
            end
          end
          default: ;
        endcase
        if ((state_nxt == S_FIN) && (cnt_nxt != 6'd0)) state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (sel_b_r) b_nxt = left_r ? {b_r[30:0], 1'b0} : {1'b0, b_r[31:1]};
        else         a_nxt = left_r ? {a_r[30:0], 1'b0} : {1'b0, a_r[31:1]};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = S_FIN;
      end
      S_NIB: begin
        // drop a nibble from the operand with fewer tracked zeros until the product fits
        if (({1'b0, lza_r} + {1'b0, lzb_r}) < {1'b0, WORD_BITS}) begin
          sa_nxt = shift_t'(sa_u + {2'b00, NIBBLE});
          if (lza_r < lzb_r) begin
            a_nxt   = {4'd0, a_r[31:4]};
            lza_nxt = lza_r + NIBBLE;
          end else begin
            b_nxt   = {4'd0, b_r[31:4]};
            lzb_nxt = lzb_r + NIBBLE;
          end
        end else begin
          acc_nxt   = '0;
          cnt_nxt   = WORD_BITS;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (b_r[0]) acc_nxt = acc_r + a_r;
        a_nxt   = {a_r[30:0], 1'b0};
        b_nxt   = {1'b0, b_r[31:1]};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = S_FIN;
      end
      S_DIV: begin
        // one quotient bit a cycle, shifted into the dividend register
        if (!div_sub[17]) rem_nxt = div_sub[15:0];
        else              rem_nxt = div_r2[15:0];
        a_nxt   = {a_r[30:0], !div_sub[17]};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = fin_value;
          out_shift_nxt = fin_shift;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    ta_r        <= ta_nxt;
    tb_r        <= tb_nxt;
    acc_r       <= acc_nxt;
    sa_r        <= sa_nxt;
    sb_r        <= sb_nxt;
    lza_r       <= lza_nxt;
    lzb_r       <= lzb_nxt;
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    sel_b_r     <= sel_b_nxt;
    left_r      <= left_nxt;
    early_r     <= early_nxt;
    keyres_r    <= keyres_nxt;
    out_value_r <= out_value_nxt;
    out_shift_r <= out_shift_nxt;
  end

`ifndef ASSERT_OFF
  a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> ((cnt_r != 6'd0) && (cnt_r <= WORD_BITS)))
    else $error("shift count out of range");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (b_r[15:0] != 16'd0))
    else $error("divide step with zero divisor");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result loaded outside finish state");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_valid_r && !out_ch.ready) |=> (state_r == S_FIN))
    else $error("pending result overwritten");
`endif

endmodule
